@@ rtl/rdsd_pkg.sv @@
// Package for the escape-RLE plus delta sample decoder.
// Holds marker bytes, field widths, item limits and shared types; depends on nothing.
`default_nettype none

package rdsd_pkg;

	localparam int BYTE_W     = 8;
	localparam int SAMPLE_W   = 16;
	localparam int COUNT_W    = 3;
	localparam int SLOTS      = 4;
	localparam int SLOT_IDX_W = $clog2(SLOTS);
	localparam int MAX_ITEMS  = 64;
	localparam int ITEM_W     = $clog2(MAX_ITEMS);
	localparam int MAX_RUN    = 256;
	localparam int REM_W      = $clog2(MAX_RUN) + 1;

	localparam int DEFAULT_SAMPLES_PER_RESULT = 4;

	localparam logic [BYTE_W-1:0] RUN_MARK  = 8'ha5;
	localparam logic [BYTE_W-1:0] LIT_MARK  = 8'h5a;
	localparam logic [BYTE_W-1:0] SIGN_FILL = 8'hff;

	typedef logic [BYTE_W-1:0]   byte_t;
	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [COUNT_W-1:0]  count_t;

endpackage

`default_nettype wire

@@ rtl/rdsd_if.sv @@
// Valid/ready channel interfaces of the decoder: compressed bytes in, sample items out.
// Depends on rdsd_pkg for payload types.
`default_nettype none

interface rdsd_byte_if;
	logic           valid;
	logic           ready;
	rdsd_pkg::byte_t in_byte;
	logic           end_of_stream;

	modport source (output valid, output in_byte, output end_of_stream, input ready);
	modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface rdsd_sample_if;
	logic              valid;
	logic              ready;
	rdsd_pkg::sample_t sample_0;
	rdsd_pkg::sample_t sample_1;
	rdsd_pkg::sample_t sample_2;
	rdsd_pkg::sample_t sample_3;
	rdsd_pkg::count_t  sample_count;
	logic              last_of_run;
	logic              stream_done;

	modport source (output valid, output sample_0, output sample_1, output sample_2,
		output sample_3, output sample_count, output last_of_run, output stream_done,
		input ready);
	modport sink   (input valid, input sample_0, input sample_1, input sample_2,
		input sample_3, input sample_count, input last_of_run, input stream_done,
		output ready);
endinterface

`default_nettype wire

@@ rtl/rle_delta_sample_decoder.sv @@
// Top level of the escape-RLE plus 16-bit delta sample decoder.
// Depends on rdsd_pkg and the channel interfaces in rdsd_if.sv.
//
//   channel   dir   modport          payload
//   stream    in    rdsd_byte_if     in_byte, end_of_stream
//   samples   out   rdsd_sample_if   sample_0..3, sample_count, last_of_run, stream_done
//
// A byte is handled in order: an accept in ST_IDLE, one delta step per sample source
// (one for a plain byte, r+1 for a run value byte, none for markers), a pass out of the
// step loop in ST_RUN and a flush in ST_FLUSH.
// The single delta adder runs one step a cycle while the output register is free.
// Steps and the flush wait while the output register holds an untaken beat.
// arst_n clears control and delta state; end of stream resets run and delta state.
`default_nettype none

module rle_delta_sample_decoder #(
	parameter int SAMPLES_PER_RESULT = rdsd_pkg::DEFAULT_SAMPLES_PER_RESULT
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rdsd_byte_if.sink    stream,
	rdsd_sample_if.source samples
);
	import rdsd_pkg::*;

	// Samples per item, clamped to the four slots
	localparam int PER = (SAMPLES_PER_RESULT < 1) ? 1 :
		((SAMPLES_PER_RESULT > SLOTS) ? SLOTS : SAMPLES_PER_RESULT);
	localparam count_t PER_CNT = COUNT_W'(PER);

	localparam logic [1:0] RPH_NORMAL = 2'd0;
	localparam logic [1:0] RPH_COUNT  = 2'd1;
	localparam logic [1:0] RPH_VALUE  = 2'd2;
	localparam logic [1:0] DPH_NORMAL = 2'd0;
	localparam logic [1:0] DPH_LOW    = 2'd1;
	localparam logic [1:0] DPH_HIGH   = 2'd2;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH} state_t;

	state_t            state_q;
	logic [1:0]        run_phase_q;
	byte_t             run_repeat_q;
	logic [1:0]        delta_phase_q;
	byte_t             literal_low_q;
	sample_t           prev_q;
	byte_t             byte_q;
	logic              eos_q;
	logic [REM_W-1:0]  rem_q;
	count_t            cnt_q;
	logic [ITEM_W-1:0] items_q;
	sample_t           pack_q [SLOTS];

	logic              out_valid_q;
	sample_t           out_q [SLOTS];
	count_t            out_cnt_q;
	logic              out_last_q;
	logic              out_done_q;

	logic              out_free;
	logic              out_load;
	logic [1:0]        d_phase_n;
	byte_t             d_lit_n;
	sample_t           d_prev_n;
	logic              d_sample;

	assign out_free     = !out_valid_q || samples.ready;
	assign stream.ready = (state_q == ST_IDLE);

	// Load the output register with a full item or with the closing item
	assign out_load = out_free && (
		(state_q == ST_RUN && rem_q != '0 && d_sample && cnt_q == PER_CNT &&
			items_q != ITEM_W'(MAX_ITEMS - 1)) ||
		(state_q == ST_FLUSH && (cnt_q != '0 || eos_q)));

	assign samples.valid        = out_valid_q;
	assign samples.sample_0     = out_q[0];
	assign samples.sample_1     = out_q[1];
	assign samples.sample_2     = out_q[2];
	assign samples.sample_3     = out_q[3];
	assign samples.sample_count = out_cnt_q;
	assign samples.last_of_run  = out_last_q;
	assign samples.stream_done  = out_done_q;

	// Shared delta step: literal escape capture or signed add to the previous sample
	always_comb begin
		d_phase_n = DPH_NORMAL;
		d_lit_n   = literal_low_q;
		d_prev_n  = prev_q;
		d_sample  = 1'b0;
		case (delta_phase_q)
			DPH_LOW: begin
				d_lit_n   = byte_q;
				d_phase_n = DPH_HIGH;
			end
			DPH_HIGH: begin
				d_prev_n = {byte_q, literal_low_q};
				d_sample = 1'b1;
			end
			default: begin
				if (byte_q == LIT_MARK) begin
					d_phase_n = DPH_LOW;
				end else begin
					d_prev_n = prev_q + (byte_q[BYTE_W-1] ? {SIGN_FILL, byte_q} :
						{{BYTE_W{1'b0}}, byte_q});
					d_sample = 1'b1;
				end
			end
		endcase
	end

	// Sequencer: accept a byte, step the delta unit, pack samples, flush the last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			run_phase_q   <= RPH_NORMAL;
			run_repeat_q  <= '0;
			delta_phase_q <= DPH_NORMAL;
			literal_low_q <= '0;
			prev_q        <= '0;
			eos_q         <= 1'b0;
			rem_q         <= '0;
			cnt_q         <= '0;
			items_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// load a new beat, or drop the current one once taken
			out_valid_q <= out_load || (out_valid_q && !samples.ready);
			case (state_q)
				ST_IDLE: begin
					if (stream.valid) begin
						byte_q  <= stream.in_byte;
						eos_q   <= stream.end_of_stream;
						cnt_q   <= '0;
						items_q <= '0;
						for (int i = 0; i < SLOTS; i++) begin
							pack_q[i] <= '0;
						end
						case (run_phase_q)
							RPH_COUNT: begin
								run_repeat_q <= stream.in_byte;
								run_phase_q  <= RPH_VALUE;
								rem_q        <= '0;
							end
							RPH_VALUE: begin
								rem_q       <= {1'b0, run_repeat_q} + REM_W'(1);
								run_phase_q <= RPH_NORMAL;
							end
							default: begin
								if (stream.in_byte == RUN_MARK) begin
									run_phase_q <= RPH_COUNT;
									rem_q       <= '0;
								end else begin
									run_phase_q <= RPH_NORMAL;
									rem_q       <= REM_W'(1);
								end
							end
						endcase
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (rem_q == '0) begin
						state_q <= ST_FLUSH;
					end else if (out_free) begin
						delta_phase_q <= d_phase_n;
						literal_low_q <= d_lit_n;
						prev_q        <= d_prev_n;
						rem_q         <= rem_q - REM_W'(1);
						if (d_sample) begin
							if (cnt_q != PER_CNT) begin
								pack_q[cnt_q[SLOT_IDX_W-1:0]] <= d_prev_n;
								cnt_q <= cnt_q + COUNT_W'(1);
							end else if (items_q != ITEM_W'(MAX_ITEMS - 1)) begin
								// hand off the full item, open a new one with this sample
								out_q       <= pack_q;
								out_cnt_q   <= cnt_q;
								out_last_q  <= 1'b0;
								out_done_q  <= 1'b0;
								items_q     <= items_q + ITEM_W'(1);
								pack_q[0]   <= d_prev_n;
								for (int i = 1; i < SLOTS; i++) begin
									pack_q[i] <= '0;
								end
								cnt_q <= COUNT_W'(1);
							end
						end
					end
				end
				ST_FLUSH: begin
					if (cnt_q == '0 && !eos_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_q       <= pack_q;
						out_cnt_q   <= cnt_q;
						out_last_q  <= 1'b1;
						out_done_q  <= eos_q;
						if (eos_q) begin
							run_phase_q   <= RPH_NORMAL;
							run_repeat_q  <= '0;
							delta_phase_q <= DPH_NORMAL;
							literal_low_q <= '0;
							prev_q        <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		stream.valid && stream.ready |=> !stream.ready)
		else $error("decoder accepted a byte while busy");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.stream_done |-> samples.last_of_run)
		else $error("stream_done without last_of_run");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid |-> samples.sample_count <= PER_CNT)
		else $error("sample_count exceeds item size");

	a_empty_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.sample_count == '0 |-> samples.stream_done)
		else $error("empty item outside end of stream");
`endif

endmodule

`default_nettype wire

@@ dv/rle_delta_sample_decoder_test.sv @@
// Self-checking bench for rle_delta_sample_decoder: drives compressed byte streams and
// checks every sample beat against an in-bench decoder model.
// Depends on rdsd_pkg and the rdsd_byte_if / rdsd_sample_if channel interfaces.
`default_nettype none

module rle_delta_sample_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rdsd_pkg::*;

	localparam int SPR          = DEFAULT_SAMPLES_PER_RESULT;
	localparam int PER          = (SPR < 1) ? 1 : ((SPR > SLOTS) ? SLOTS : SPR);
	localparam int RANDOM_BYTES = 85;
	localparam int DRAIN_CYCLES = 300;
	localparam int STALL_LIMIT  = 2000;

	typedef enum logic [1:0] {RUN_NONE, RUN_COUNT_DUE, RUN_VALUE_DUE} run_phase_e;
	typedef enum logic [1:0] {DELTA_NONE, DELTA_LOW_DUE, DELTA_HIGH_DUE} delta_phase_e;

	typedef struct packed {
		logic  end_of_stream;
		byte_t data;
	} byte_beat_t;

	typedef struct packed {
		sample_t sample_0;
		sample_t sample_1;
		sample_t sample_2;
		sample_t sample_3;
		count_t  sample_count;
		logic    last_of_run;
		logic    stream_done;
	} sample_item_t;

	// Hand-picked opening sequence: sign extremes, literal wrap, runs of one and of 256,
	// a run of escape bytes, and streams that end with an escape still open.
	localparam int DIRECTED_COUNT = 25;
	localparam logic [8:0] DIRECTED [DIRECTED_COUNT] = '{
		{1'b0, 8'h00}, {1'b0, 8'h7f}, {1'b0, 8'h80}, {1'b0, 8'hff},
		{1'b0, LIT_MARK}, {1'b0, 8'hff}, {1'b0, 8'hff}, {1'b0, 8'h01},
		{1'b0, RUN_MARK}, {1'b0, 8'h00}, {1'b0, 8'h11},
		{1'b0, RUN_MARK}, {1'b0, 8'hff}, {1'b0, 8'h81},
		{1'b0, RUN_MARK}, {1'b0, 8'h03}, {1'b0, LIT_MARK}, {1'b0, 8'h34}, {1'b1, 8'h12},
		{1'b1, RUN_MARK},
		{1'b0, LIT_MARK}, {1'b1, 8'h77},
		{1'b0, RUN_MARK}, {1'b1, 8'h02},
		{1'b1, 8'h42}
	};

	logic clk;
	logic arst_n;

	rdsd_byte_if   byte_bus ();
	rdsd_sample_if sample_bus ();

	rle_delta_sample_decoder #(
		.SAMPLES_PER_RESULT(SPR)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (byte_bus),
		.samples (sample_bus)
	);

	// Decoder model state
	run_phase_e   run_ph      = RUN_NONE;
	byte_t        run_count   = '0;
	delta_phase_e delta_ph    = DELTA_NONE;
	byte_t        lit_low     = '0;
	sample_t      last_sample = '0;
	sample_t      fresh_samples[$];

	byte_beat_t   compressed_bytes[$];
	sample_item_t owed_sample_items[$];

	int   mismatches  = 0;
	int   idle_cycles = 0;
	int   bytes_accepted = 0;
	int   total_bytes = 0;
	logic byte_taken  = 1'b0;
	logic item_taken  = 1'b0;

	// Sender burst/gap and receiver stall pattern
	int          burst_left = 0;
	int          gap_left   = 0;
	logic [15:0] rdy_pat    = 16'hffff;
	int          rdy_phase  = 0;

	// Delta stage: literal escape or signed step on the previous sample
	function automatic void push_delta(byte_t b);
		case (delta_ph)
			DELTA_LOW_DUE: begin
				lit_low  = b;
				delta_ph = DELTA_HIGH_DUE;
			end
			DELTA_HIGH_DUE: begin
				last_sample = {b, lit_low};
				delta_ph    = DELTA_NONE;
				fresh_samples.insert(fresh_samples.size(), last_sample);
			end
			default: begin
				delta_ph = DELTA_NONE;
				if (b == LIT_MARK) begin
					delta_ph = DELTA_LOW_DUE;
				end else begin
					last_sample = last_sample + {(b[7] ? SIGN_FILL : 8'h00), b};
					fresh_samples.insert(fresh_samples.size(), last_sample);
				end
			end
		endcase
	endfunction

	// Run stage, then pack the samples of this byte into owed beats
	function automatic void expand_byte(byte_t b, logic eos);
		int n_items;
		int cnt;
		int base;
		int k;
		int j;
		int r;
		sample_t slot [SLOTS];
		sample_item_t item;

		fresh_samples.delete();
		case (run_ph)
			RUN_COUNT_DUE: begin
				run_count = b;
				run_ph    = RUN_VALUE_DUE;
			end
			RUN_VALUE_DUE: begin
				for (r = 0; r <= int'(run_count); r++)
					push_delta(b);
				run_ph = RUN_NONE;
			end
			default: begin
				run_ph = RUN_NONE;
				if (b == RUN_MARK)
					run_ph = RUN_COUNT_DUE;
				else
					push_delta(b);
			end
		endcase

		n_items = (fresh_samples.size() + PER - 1) / PER;
		if (eos && n_items == 0)
			n_items = 1;
		if (n_items > MAX_ITEMS)
			n_items = MAX_ITEMS;

		for (k = 0; k < n_items; k++) begin
			base = k * PER;
			cnt  = fresh_samples.size() - base;
			if (cnt < 0)
				cnt = 0;
			if (cnt > PER)
				cnt = PER;
			for (j = 0; j < SLOTS; j++)
				slot[j] = (j < cnt) ? fresh_samples[base + j] : '0;
			item.sample_0     = slot[0];
			item.sample_1     = slot[1];
			item.sample_2     = slot[2];
			item.sample_3     = slot[3];
			item.sample_count = count_t'(cnt);
			item.last_of_run  = (k == n_items - 1);
			item.stream_done  = (k == n_items - 1) && eos;
			owed_sample_items.insert(owed_sample_items.size(), item);
		end

		// End of stream drops any open escape and restarts the decoder
		if (eos) begin
			run_ph      = RUN_NONE;
			run_count   = '0;
			delta_ph    = DELTA_NONE;
			lit_low     = '0;
			last_sample = '0;
		end
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void add_beat(byte_t b, logic eos);
		byte_beat_t beat;
		beat.data          = b;
		beat.end_of_stream = eos;
		compressed_bytes.insert(compressed_bytes.size(), beat);
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Monitor: predict on accepted bytes, check accepted sample beats
	always @(posedge clk) begin
		sample_item_t want;
		if (arst_n) begin
			byte_taken = byte_bus.valid && byte_bus.ready;
			item_taken = sample_bus.valid && sample_bus.ready;
			if (byte_taken) begin
				expand_byte(byte_bus.in_byte, byte_bus.end_of_stream);
				bytes_accepted++;
			end
			if (item_taken) begin
				if (owed_sample_items.size() == 0) begin
					$error("sample beat with none owed: count %0d", sample_bus.sample_count);
					mismatches++;
				end else begin
					want = owed_sample_items.pop_front();
					check_field("sample_0", want.sample_0, sample_bus.sample_0);
					check_field("sample_1", want.sample_1, sample_bus.sample_1);
					check_field("sample_2", want.sample_2, sample_bus.sample_2);
					check_field("sample_3", want.sample_3, sample_bus.sample_3);
					check_field("sample_count", want.sample_count, sample_bus.sample_count);
					check_field("last_of_run", want.last_of_run, sample_bus.last_of_run);
					check_field("stream_done", want.stream_done, sample_bus.stream_done);
				end
			end
			idle_cycles = (byte_taken || item_taken) ? 0 : idle_cycles + 1;
		end
	end

	// Driver: bytes in bursts with gaps, ready on a rotating stall pattern
	always @(negedge clk) begin
		byte_beat_t beat;
		if (arst_n) begin
			if (!byte_bus.valid || byte_taken) begin
				if (gap_left > 0 || compressed_bytes.size() == 0) begin
					byte_bus.valid <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end else begin
					beat = compressed_bytes.pop_front();
					byte_bus.valid         <= 1'b1;
					byte_bus.in_byte       <= beat.data;
					byte_bus.end_of_stream <= beat.end_of_stream;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 16);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end
			end

			sample_bus.ready <= rdy_pat[0];
			rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
			rdy_phase++;
			if (rdy_phase == 16) begin
				rdy_phase = 0;
				rdy_pat = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
			end
		end
	end

	initial begin : watchdog
		wait (idle_cycles >= STALL_LIMIT);
		$display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int i;
		int n_tokens;
		int t;
		int kind;
		byte_t b;
		byte_beat_t tail;

		arst_n                 = 1'b0;
		byte_bus.valid         = 1'b0;
		byte_bus.in_byte       = '0;
		byte_bus.end_of_stream = 1'b0;
		sample_bus.ready       = 1'b0;

		for (i = 0; i < DIRECTED_COUNT; i++)
			compressed_bytes.insert(compressed_bytes.size(), byte_beat_t'(DIRECTED[i]));

		// Random streams: mostly well-formed tokens, some raw noise and cut-off tails
		while (compressed_bytes.size() < DIRECTED_COUNT + RANDOM_BYTES) begin
			n_tokens = $urandom_range(1, 8);
			for (t = 0; t < n_tokens; t++) begin
				kind = $urandom_range(0, 9);
				if (kind < 4) begin
					b = byte_t'($urandom);
					if (b == RUN_MARK || b == LIT_MARK)
						b = b ^ 8'h01;
					add_beat(b, 1'b0);
				end else if (kind < 6) begin
					add_beat(LIT_MARK, 1'b0);
					add_beat(byte_t'($urandom), 1'b0);
					add_beat(byte_t'($urandom), 1'b0);
				end else if (kind < 8) begin
					add_beat(RUN_MARK, 1'b0);
					if ($urandom_range(0, 9) == 0)
						add_beat(byte_t'($urandom_range(0, 255)), 1'b0);
					else
						add_beat(byte_t'($urandom_range(0, 7)), 1'b0);
					add_beat(byte_t'($urandom), 1'b0);
				end else begin
					add_beat(byte_t'($urandom), 1'b0);
				end
			end
			if ($urandom_range(0, 4) == 0 && compressed_bytes.size() > DIRECTED_COUNT + 1)
				void'(compressed_bytes.pop_back());
			tail = compressed_bytes.pop_back();
			tail.end_of_stream = 1'b1;
			compressed_bytes.insert(compressed_bytes.size(), tail);
		end
		total_bytes = compressed_bytes.size();

		// Hold reset, release on a falling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for all bytes to go in and all owed beats to come out, then drain
		while (bytes_accepted < total_bytes)
			@(posedge clk);
		while (owed_sample_items.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && owed_sample_items.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ rle_delta_sample_decoder.f @@
rtl/rdsd_pkg.sv
rtl/rdsd_if.sv
rtl/rle_delta_sample_decoder.sv
dv/rle_delta_sample_decoder_test.sv
